// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define GDD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define GDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and the month table of the date difference block.
// ----------------------------------------------------------------------------
package gdd_pkg;

    // Field widths
    localparam int C_DAY_W   = 5;
    localparam int C_MONTH_W = 4;
    localparam int C_YEAR_W  = 14;
    localparam int C_NUM_W   = 22;
    localparam int C_MDAY_W  = 9;

    // Stream payload widths (padded to bytes)
    localparam int C_S_TDATA_W = 48;
    localparam int C_M_TDATA_W = 24;

    // Years above this are saturated
    localparam logic [C_YEAR_W-1:0] C_MAX_YEAR = 14'd9999;

    // floor(x / 25) = (x * 5243) >> 17, exact for x below 43690
    localparam logic [12:0] C_RECIP_25  = 13'd5243;
    localparam int          C_RECIP_SH  = 17;

    // Per-stage load enables of the day number pipeline
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
        logic s4_load;
    } t_dn_ctrl;

    // Days before a month in a common year; month 0 reads as January,
    // anything past December as the whole year
    function automatic logic [C_MDAY_W-1:0] f_days_before(input logic [C_MONTH_W-1:0] month);
        logic [C_MDAY_W-1:0] days;
        unique case (month) inside
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            4'd12:      days = 9'd334;
            default:    days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_difference.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Absolute number of days between two proleptic Gregorian dates.
// ----------------------------------------------------------------------------
// Takes one date pair per cycle unless output back-pressure fills the pipeline,
// and returns one day count per pair, in order. From input request to output request, four stages
// form each date's day number (year saturation, reciprocal multiplies for the
// divisions by 25 and 100, year and month sums, final add), the fifth takes
// the absolute difference. Each stage advances when its successor is free,
// so a stall at the output holds every request in place and bubbles close up.
// Years above 9999 are treated as 9999; days and months are not checked.
`include "assert_macros.svh"

module gregorian_date_difference (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: first_day[4:0] first_month[8:5] first_year[22:9]
    //        second_day[27:23] second_month[31:28] second_year[45:32], zero pad
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [gdd_pkg::C_S_TDATA_W-1:0]  i_s_tdata,
    // tdata: day_difference[21:0], zero pad
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [gdd_pkg::C_M_TDATA_W-1:0]  o_m_tdata
);
    import gdd_pkg::*;

    localparam int C_STAGES = 5;

    logic [C_STAGES-1:0] r_valid;
    logic [C_STAGES-1:0] n_load;
    logic [C_NUM_W-1:0]  r_diff;
    logic [C_NUM_W-1:0]  w_num_a;
    logic [C_NUM_W-1:0]  w_num_b;
    t_dn_ctrl            w_ctrl;

    // Stage advance: free or its content moves on
    always_comb begin
        n_load[C_STAGES-1] = !r_valid[C_STAGES-1] || i_m_tready;
        for (int k = C_STAGES - 2; k >= 0; k--) begin
            n_load[k] = !r_valid[k] || n_load[k+1];
        end
        w_ctrl.s1_load = n_load[0];
        w_ctrl.s2_load = n_load[1];
        w_ctrl.s3_load = n_load[2];
        w_ctrl.s4_load = n_load[3];
    end

    assign o_s_tready = n_load[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_load[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k < C_STAGES; k++) begin
                if (n_load[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Day numbers of both dates
    gdd_day_number u_first (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_day     (i_s_tdata[4:0]),
        .i_month   (i_s_tdata[8:5]),
        .i_year    (i_s_tdata[22:9]),
        .o_day_num (w_num_a)
    );

    gdd_day_number u_second (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_day     (i_s_tdata[27:23]),
        .i_month   (i_s_tdata[31:28]),
        .i_year    (i_s_tdata[45:32]),
        .o_day_num (w_num_b)
    );

    // Absolute difference into the output register
    always_ff @(posedge i_clk) begin
        if (n_load[C_STAGES-1]) begin
            r_diff <= (w_num_a >= w_num_b) ? (w_num_a - w_num_b) : (w_num_b - w_num_a);
        end
    end

    assign o_m_tvalid = r_valid[C_STAGES-1];
    assign o_m_tdata  = {{(C_M_TDATA_W - C_NUM_W){1'b0}}, r_diff};

    // A ready sink never back-pressures the input
    `GDD_ASSERT(a_no_stall_through, i_clk, i_rst_n, i_m_tready |-> o_s_tready, "input stalled while output ready")
    // A new result only comes from a valid fourth stage
    `GDD_ASSERT(a_out_source, i_clk, i_rst_n, (o_m_tvalid && !$past(o_m_tvalid)) |-> $past(r_valid[C_STAGES-2]), "output valid without a source request")
    // Nothing leaves the pipeline straight after reset
    `GDD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

// ===== hw/rtl/gdd_day_number.sv =====
// ----------------------------------------------------------------------------
// gdd_day_number
// Four-stage pipeline turning one date into its day number.
// ----------------------------------------------------------------------------
module gdd_day_number (
    input  logic                           i_clk,
    input  gdd_pkg::t_dn_ctrl              i_ctrl,
    input  logic [gdd_pkg::C_DAY_W-1:0]    i_day,
    input  logic [gdd_pkg::C_MONTH_W-1:0]  i_month,
    input  logic [gdd_pkg::C_YEAR_W-1:0]   i_year,
    output logic [gdd_pkg::C_NUM_W-1:0]    o_day_num
);
    import gdd_pkg::*;

    // Stage 1: saturated year
    logic [C_DAY_W-1:0]   r1_day;
    logic [C_MONTH_W-1:0] r1_month;
    logic [C_YEAR_W-1:0]  r1_year;

    // Stage 2: year, years before it, quotients by 25 and by 100
    logic [C_DAY_W-1:0]   r2_day;
    logic [C_MONTH_W-1:0] r2_month;
    logic [C_YEAR_W-1:0]  r2_year;
    logic [C_YEAR_W-1:0]  r2_prev;
    logic [9:0]           r2_q_year;   // year / 25
    logic [7:0]           r2_q_prev;   // prev / 100

    // Stage 3: year and month contributions
    logic [C_DAY_W-1:0]   r3_day;
    logic [C_NUM_W-1:0]   r3_years;
    logic [C_MDAY_W-1:0]  r3_mdays;

    // Stage 4: final day number
    logic [C_NUM_W-1:0]   r4_num;

    logic [C_YEAR_W-1:0]  n_prev;
    logic [26:0]          n_prod_year;
    logic [24:0]          n_prod_prev;
    logic [C_YEAR_W-1:0]  n_q25;
    logic                 n_leap;
    logic [C_NUM_W-1:0]   n_years;
    logic [C_MDAY_W-1:0]  n_mdays;

    // Stage 1 load
    always_ff @(posedge i_clk) begin
        if (i_ctrl.s1_load) begin
            r1_day   <= i_day;
            r1_month <= i_month;
            r1_year  <= (i_year > C_MAX_YEAR) ? C_MAX_YEAR : i_year;
        end
    end

    // Reciprocal multiplies for the divisions by 25 and by 100
    always_comb begin
        n_prev      = (r1_year == '0) ? '0 : r1_year - 14'd1;
        n_prod_year = 27'(r1_year) * 27'(C_RECIP_25);
        n_prod_prev = 25'(n_prev[C_YEAR_W-1:2]) * 25'(C_RECIP_25);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s2_load) begin
            r2_day    <= r1_day;
            r2_month  <= r1_month;
            r2_year   <= r1_year;
            r2_prev   <= n_prev;
            r2_q_year <= n_prod_year[C_RECIP_SH+9:C_RECIP_SH];
            r2_q_prev <= n_prod_prev[C_RECIP_SH+7:C_RECIP_SH];
        end
    end

    // Leap test, closed-form count of whole years and days before the month
    always_comb begin
        n_q25   = 14'(r2_q_year) * 14'd25;
        // div by 4 and not by 25, or div by 16 and by 25 (i.e. by 400)
        n_leap  = (r2_year[1:0] == 2'd0) &&
                  ((r2_year != n_q25) || (r2_year[3:0] == 4'd0));
        n_years = 22'(r2_prev) * 22'd365 + 22'(r2_prev[C_YEAR_W-1:2])
                  - 22'(r2_q_prev) + 22'(r2_q_prev[7:2]);
        n_mdays = f_days_before(r2_month)
                  + 9'(n_leap && (r2_month > 4'd2));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s3_load) begin
            r3_day   <= r2_day;
            r3_years <= n_years;
            r3_mdays <= n_mdays;
        end
    end

    // Sum of the parts
    always_ff @(posedge i_clk) begin
        if (i_ctrl.s4_load) begin
            r4_num <= r3_years + 22'(r3_mdays) + 22'(r3_day);
        end
    end

    assign o_day_num = r4_num;

endmodule
